### src/gqlw_pkg.sv
// ----------------------------------------------------------------------------
// gqlw_pkg: shared types and constants for the glyph quad layout unit
// Command codes, register indexes, glyph table entry, stage records and
// saturation helpers used across the layout pipeline.
// ----------------------------------------------------------------------------
package gqlw_pkg;

	localparam int GLYPH_ENTRIES = 256;
	localparam int MAX_CHARS     = 1024;
	localparam int FRAC_BITS     = 16;

	localparam int GI_W = $clog2(GLYPH_ENTRIES);
	localparam int CC_W = $clog2(MAX_CHARS);

	// command codes of an input beat
	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_RESTART = 2'd1;
	localparam logic [1:0] CMD_LAYOUT  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] CFG_LINE_WIDTH = 3'd2;
	localparam logic [2:0] CFG_INV_TEX_W  = 3'd3;
	localparam logic [2:0] CFG_INV_TEX_H  = 3'd4;
	localparam logic [2:0] CFG_LINE_STEP  = 3'd5;

	// register reset values
	localparam logic signed [20:0] ORIGIN_X_RST   = 21'sd0;
	localparam logic signed [20:0] ORIGIN_Y_RST   = 21'sd0;
	localparam logic [19:0]        LINE_WIDTH_RST = 20'd65536;
	localparam logic [16:0]        INV_TEX_W_RST  = 17'd256;
	localparam logic [16:0]        INV_TEX_H_RST  = 17'd256;
	localparam logic [19:0]        LINE_STEP_RST  = 20'd6554;

	localparam logic [7:0] SPACE_CODE  = 8'd32;
	localparam logic [1:0] LAST_CORNER = 2'd3;

	// 1.0 in the working precision
	localparam logic signed [32:0] ONE_Q = 33'(1) << FRAC_BITS;

	typedef struct packed {
		logic        [11:0] gx;
		logic        [11:0] gy;
		logic        [11:0] gw;
		logic        [11:0] gh;
		logic signed [11:0] xoff;
		logic signed [11:0] yoff;
		logic        [11:0] xadv;
	} glyph_t;

	typedef struct packed {
		logic signed [20:0] origin_x;
		logic signed [20:0] origin_y;
		logic        [19:0] line_width;
		logic        [16:0] inv_w;
		logic        [16:0] inv_h;
		logic        [19:0] line_step;
	} cfg_t;

	// record leaving the table lookup stage
	typedef struct packed {
		logic       restart;
		logic [7:0] code;
		glyph_t     g;
	} lookup_t;

	// record leaving the metric stages
	typedef struct packed {
		logic               restart;
		logic        [7:0]  code;
		logic        [28:0] cw;
		logic signed [29:0] yo;
		logic signed [30:0] chyo;
		logic signed [30:0] adv;
		logic signed [17:0] u1;
		logic signed [17:0] u2;
		logic signed [17:0] v1;
		logic signed [17:0] v2;
	} metric_t;

	function automatic logic signed [20:0] sat21(input logic signed [32:0] v);
		if (v > 33'sh0_000F_FFFF)
			return 21'sh0F_FFFF;
		else if (v < 33'sh1_FFF0_0000)
			return 21'sh10_0000;
		else
			return v[20:0];
	endfunction

	function automatic logic signed [17:0] sat18(input logic signed [32:0] v);
		if (v > 33'sh0_0001_FFFF)
			return 18'sh1_FFFF;
		else if (v < 33'sh1_FFFE_0000)
			return 18'sh2_0000;
		else
			return v[17:0];
	endfunction

endpackage

### src/gqlw_glyph_ram.sv
// ----------------------------------------------------------------------------
// gqlw_glyph_ram: glyph metric table and lookup stage
// Writes glyph entries on load beats and reads the entry of a laid-out
// character through a registered read. Per-entry valid bits make unloaded
// entries read as zero straight after reset.
// ----------------------------------------------------------------------------
module gqlw_glyph_ram import gqlw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [1:0] cmd,
	input  logic [7:0] code,
	input  glyph_t     wr_g,
	input  logic       adv,
	output logic       s1_v,
	output lookup_t    lk
);

	glyph_t              glyph_mem [GLYPH_ENTRIES];
	glyph_t              rd_s1;
	logic [GLYPH_ENTRIES-1:0] ok_q;
	logic                s1_v_q;
	logic                restart_s1;
	logic                hit_s1;
	logic [7:0]          code_s1;
	logic [GI_W-1:0]     idx;
	logic                in_rng;
	logic                wr_en;

	assign idx    = code[GI_W-1:0];
	assign in_rng = ({1'b0, code} < 9'(GLYPH_ENTRIES));
	assign wr_en  = acc && (cmd == CMD_LOAD) && in_rng;

	// write on load, read on every accepted beat
	always_ff @(posedge clk) begin
		if (wr_en)
			glyph_mem[idx] <= wr_g;
		if (acc)
			rd_s1 <= glyph_mem[idx];
	end

	// mark loaded entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= '0;
		end else if (wr_en) begin
			ok_q[idx] <= 1'b1;
		end
	end

	// hold layout and restart beats in the lookup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (acc) begin
			s1_v_q <= (cmd == CMD_LAYOUT) || (cmd == CMD_RESTART);
		end else if (adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			restart_s1 <= (cmd == CMD_RESTART);
			code_s1    <= code;
			hit_s1     <= in_rng && ok_q[idx];
		end
	end

	assign s1_v       = s1_v_q;
	assign lk.restart = restart_s1;
	assign lk.code    = code_s1;
	assign lk.g       = hit_s1 ? rd_s1 : '0;

endmodule

### src/gqlw_metric.sv
// ----------------------------------------------------------------------------
// gqlw_metric: scaling of glyph metrics
// Stage two multiplies the pixel metrics by the atlas reciprocals; stage
// three forms texture corners, advance and vertical extents.
// ----------------------------------------------------------------------------
module gqlw_metric import gqlw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_v,
	input  lookup_t     lk,
	input  logic [16:0] inv_w,
	input  logic [16:0] inv_h,
	input  logic        out_take,
	output logic        take,
	output logic        s3_v,
	output metric_t     m
);

	logic               s2_v_q, s3_v_q;
	logic               s2_rdy, s3_rdy;
	logic               restart_s2;
	logic [7:0]         code_s2;
	logic [28:0]        p_gw_s2, p_gh_s2, p_gx_s2, p_gy_s2, p_xa_s2;
	logic signed [29:0] p_xo_s2, p_yo_s2;
	logic [28:0]        p_gw, p_gh, p_gx, p_gy, p_xa;
	logic signed [29:0] p_xo, p_yo;
	logic signed [32:0] u1w, u2w, v1w, v2w, chyo_w, adv_w;
	metric_t            m_s3;

	assign s3_rdy = !s3_v_q || out_take;
	assign s2_rdy = !s2_v_q || s3_rdy;
	assign take   = s2_rdy;

	// scale pixel metrics
	assign p_gw = {17'b0, lk.g.gw} * {12'b0, inv_w};
	assign p_gh = {17'b0, lk.g.gh} * {12'b0, inv_h};
	assign p_gx = {17'b0, lk.g.gx} * {12'b0, inv_w};
	assign p_gy = {17'b0, lk.g.gy} * {12'b0, inv_h};
	assign p_xa = {17'b0, lk.g.xadv} * {12'b0, inv_w};
	assign p_xo = lk.g.xoff * $signed({1'b0, inv_w});
	assign p_yo = lk.g.yoff * $signed({1'b0, inv_h});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
			s3_v_q <= 1'b0;
		end else begin
			if (s2_rdy)
				s2_v_q <= in_v;
			if (s3_rdy)
				s3_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_rdy) begin
			restart_s2 <= lk.restart;
			code_s2    <= lk.code;
			p_gw_s2    <= p_gw;
			p_gh_s2    <= p_gh;
			p_gx_s2    <= p_gx;
			p_gy_s2    <= p_gy;
			p_xa_s2    <= p_xa;
			p_xo_s2    <= p_xo;
			p_yo_s2    <= p_yo;
		end
	end

	// form texture corners and advance
	always_comb begin
		u1w    = $signed({4'b0, p_gx_s2});
		u2w    = $signed({4'b0, p_gx_s2}) + $signed({4'b0, p_gw_s2});
		v1w    = ONE_Q - $signed({4'b0, p_gy_s2});
		v2w    = v1w - $signed({4'b0, p_gh_s2});
		chyo_w = $signed({4'b0, p_gh_s2}) + $signed({{3{p_yo_s2[29]}}, p_yo_s2});
		adv_w  = $signed({4'b0, p_xa_s2}) + $signed({{3{p_xo_s2[29]}}, p_xo_s2});
	end

	always_ff @(posedge clk) begin
		if (s3_rdy) begin
			m_s3.restart <= restart_s2;
			m_s3.code    <= code_s2;
			m_s3.cw      <= p_gw_s2;
			m_s3.yo      <= p_yo_s2;
			m_s3.chyo    <= chyo_w[30:0];
			m_s3.adv     <= adv_w[30:0];
			m_s3.u1      <= sat18(u1w);
			m_s3.u2      <= sat18(u2w);
			m_s3.v1      <= sat18(v1w);
			m_s3.v2      <= sat18(v2w);
		end
	end

	assign s3_v = s3_v_q;
	assign m    = m_s3;

endmodule

### src/gqlw_emit.sv
// ----------------------------------------------------------------------------
// gqlw_emit: cursor update and corner emitter
// Places each quad at the cursor, advances the cursor with word wrap on
// spaces, and sends the four corners as one beat each.
// ----------------------------------------------------------------------------
module gqlw_emit import gqlw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s3_v,
	input  metric_t            m,
	input  cfg_t               cfg,
	input  logic               out_stall,
	output logic               take,
	output logic               out_valid,
	output logic signed [20:0] vert_x,
	output logic signed [20:0] vert_y,
	output logic signed [17:0] tex_u,
	output logic signed [17:0] tex_v,
	output logic [11:0]        vertex_number,
	output logic               last
);

	logic signed [20:0] cur_x_q, cur_y_q, run_q;
	logic               wrap_q;
	logic [CC_W-1:0]    cc_q;
	logic               em_v_q;
	logic [1:0]         corner_q;
	logic signed [20:0] left_q, right_q, top_q, bot_q;
	logic signed [17:0] u1_q, u2_q, v1_q, v2_q;
	logic [11:0]        vn_base_q;

	logic               em_free, load, restart;
	logic signed [32:0] cxw, cyw;
	logic signed [20:0] top, bot, right, run_new, cx_new;
	logic               wrap_now, do_wrap;

	assign em_free = !em_v_q || ((corner_q == LAST_CORNER) && !out_stall);
	assign load    = s3_v && !m.restart && em_free;
	assign restart = s3_v && m.restart;
	assign take    = load || restart;

	// place quad and advance cursor
	always_comb begin
		cxw      = $signed({{12{cur_x_q[20]}}, cur_x_q});
		cyw      = $signed({{12{cur_y_q[20]}}, cur_y_q});
		top      = sat21(cyw - $signed({{3{m.yo[29]}}, m.yo}));
		bot      = sat21(cyw - $signed({{2{m.chyo[30]}}, m.chyo}));
		right    = sat21(cxw + $signed({4'b0, m.cw}));
		run_new  = sat21($signed({{12{run_q[20]}}, run_q}) +
			$signed({{2{m.adv[30]}}, m.adv}));
		cx_new   = sat21(cxw + $signed({{2{m.adv[30]}}, m.adv}));
		wrap_now = wrap_q ||
			($signed({{12{run_new[20]}}, run_new}) >= $signed({13'b0, cfg.line_width}));
		do_wrap  = wrap_now && (m.code == SPACE_CODE);
	end

	// cursor and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= ORIGIN_X_RST;
			cur_y_q <= ORIGIN_Y_RST;
			run_q   <= '0;
			wrap_q  <= 1'b0;
			cc_q    <= '0;
		end else if (restart) begin
			cur_x_q <= cfg.origin_x;
			cur_y_q <= cfg.origin_y;
			run_q   <= '0;
			wrap_q  <= 1'b0;
			cc_q    <= '0;
		end else if (load) begin
			if (do_wrap) begin
				cur_x_q <= cfg.origin_x;
				cur_y_q <= sat21(cyw - $signed({13'b0, cfg.line_step}));
				run_q   <= '0;
				wrap_q  <= 1'b0;
			end else begin
				cur_x_q <= cx_new;
				run_q   <= run_new;
				wrap_q  <= wrap_now;
			end
			if (cc_q == CC_W'(MAX_CHARS - 1))
				cc_q <= '0;
			else
				cc_q <= cc_q + 1'b1;
		end
	end

	// step through the four corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_q   <= 1'b0;
			corner_q <= '0;
		end else if (load) begin
			em_v_q   <= 1'b1;
			corner_q <= '0;
		end else if (em_v_q && !out_stall) begin
			if (corner_q == LAST_CORNER)
				em_v_q <= 1'b0;
			corner_q <= corner_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q    <= cur_x_q;
			right_q   <= right;
			top_q     <= top;
			bot_q     <= bot;
			u1_q      <= m.u1;
			u2_q      <= m.u2;
			v1_q      <= m.v1;
			v2_q      <= m.v2;
			vn_base_q <= 12'({cc_q, 2'b00});
		end
	end

	// corner select: top-left, bottom-left, bottom-right, top-right
	always_comb begin
		case (corner_q)
			2'd0: begin
				vert_x = left_q;  vert_y = top_q; tex_u = u1_q; tex_v = v1_q;
			end
			2'd1: begin
				vert_x = left_q;  vert_y = bot_q; tex_u = u1_q; tex_v = v2_q;
			end
			2'd2: begin
				vert_x = right_q; vert_y = bot_q; tex_u = u2_q; tex_v = v2_q;
			end
			default: begin
				vert_x = right_q; vert_y = top_q; tex_u = u2_q; tex_v = v1_q;
			end
		endcase
	end

	assign out_valid     = em_v_q;
	assign vertex_number = vn_base_q | {10'b0, corner_q};
	assign last          = (corner_q == LAST_CORNER);

endmodule

### src/glyph_quad_layout_wrap_unit.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_wrap_unit: bitmap font quad layout with word wrap
// The first corner of a character is offered once its beat has passed the
// lookup, metric and emitter registers; the other corners follow one a cycle
// while the receiver does not stall. The corner emitter sends one corner per
// beat, four per character, and takes the next character as the last corner
// is taken; load beats end at the glyph table and restart beats emit no corners.
// Reset clears the glyph table valid bits, cursor and configuration registers at once.
// ----------------------------------------------------------------------------
module glyph_quad_layout_wrap_unit import gqlw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         char_code,
	input  logic [11:0]        glyph_x,
	input  logic [11:0]        glyph_y,
	input  logic [11:0]        glyph_width,
	input  logic [11:0]        glyph_height,
	input  logic signed [11:0] glyph_xoffset,
	input  logic signed [11:0] glyph_yoffset,
	input  logic [11:0]        glyph_xadvance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [20:0] vert_x,
	output logic signed [20:0] vert_y,
	output logic signed [17:0] tex_u,
	output logic signed [17:0] tex_v,
	output logic [11:0]        vertex_number,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [20:0]        cfg_data
);

	cfg_t    cfg_q;
	glyph_t  wr_g;
	lookup_t lk;
	metric_t m;
	logic    acc, s1_v, s1_adv, s3_v, s3_take;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= ORIGIN_X_RST;
			cfg_q.origin_y   <= ORIGIN_Y_RST;
			cfg_q.line_width <= LINE_WIDTH_RST;
			cfg_q.inv_w      <= INV_TEX_W_RST;
			cfg_q.inv_h      <= INV_TEX_H_RST;
			cfg_q.line_step  <= LINE_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:   cfg_q.origin_x   <= $signed(cfg_data);
				CFG_ORIGIN_Y:   cfg_q.origin_y   <= $signed(cfg_data);
				CFG_LINE_WIDTH: cfg_q.line_width <= cfg_data[19:0];
				CFG_INV_TEX_W:  cfg_q.inv_w      <= cfg_data[16:0];
				CFG_INV_TEX_H:  cfg_q.inv_h      <= cfg_data[16:0];
				CFG_LINE_STEP:  cfg_q.line_step  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	// accept a beat when the lookup stage is free or moving on
	assign in_stall = s1_v && !s1_adv;
	assign acc      = in_valid && !in_stall;

	assign wr_g.gx   = glyph_x;
	assign wr_g.gy   = glyph_y;
	assign wr_g.gw   = glyph_width;
	assign wr_g.gh   = glyph_height;
	assign wr_g.xoff = glyph_xoffset;
	assign wr_g.yoff = glyph_yoffset;
	assign wr_g.xadv = glyph_xadvance;

	gqlw_glyph_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.cmd    (cmd),
		.code   (char_code),
		.wr_g   (wr_g),
		.adv    (s1_adv),
		.s1_v   (s1_v),
		.lk     (lk)
	);

	gqlw_metric u_metric (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (s1_v),
		.lk       (lk),
		.inv_w    (cfg_q.inv_w),
		.inv_h    (cfg_q.inv_h),
		.out_take (s3_take),
		.take     (s1_adv),
		.s3_v     (s3_v),
		.m        (m)
	);

	gqlw_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.s3_v          (s3_v),
		.m             (m),
		.cfg           (cfg_q),
		.out_stall     (out_stall),
		.take          (s3_take),
		.out_valid     (out_valid),
		.vert_x        (vert_x),
		.vert_y        (vert_y),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.vertex_number (vertex_number),
		.last          (last)
	);

	// corners of one character go out back to back in numbering order
	a_corner_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
			(out_valid && (vertex_number == 12'($past(vertex_number) + 12'd1))))
		else $error("corner sequence broken");

	// last flag marks the fourth corner only
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (vertex_number[1:0] == LAST_CORNER)))
		else $error("last flag off the fourth corner");

	// a character does not leave the metric stage while corners are pending
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_v && !m.restart && out_valid && (out_stall || !last)) |-> !s3_take)
		else $error("character taken over pending corners");

endmodule

### verif/glyph_quad_layout_wrap_unit_tb.sv
// ----------------------------------------------------------------------------
// glyph_quad_layout_wrap_unit_tb: self-checking bench for the glyph quad unit
// Loads glyph metrics, lays out characters and restarts the cursor under
// several register settings and idling patterns. A scoreboard predicts the
// four corners of every character and checks each corner beat in order.
// ----------------------------------------------------------------------------
module glyph_quad_layout_wrap_unit_tb import gqlw_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// codes the block must ignore
	localparam logic [1:0] CMD_SPARE   = 2'd3;
	localparam logic [2:0] CFG_SPARE_A = 3'd6;
	localparam logic [2:0] CFG_SPARE_B = 3'd7;

	localparam logic [7:0] CODE_UPPER_A = 8'd65;
	localparam logic [7:0] CODE_LOWER_A = 8'd97;
	localparam logic [7:0] CODE_TOP     = 8'd255;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] code;
		glyph_t     g;
	} beat_t;

	typedef struct packed {
		logic signed [20:0] x;
		logic signed [20:0] y;
		logic signed [17:0] u;
		logic signed [17:0] v;
		logic        [11:0] num;
		logic               last;
	} corner_t;

	// layout predictor and store of corners still due
	class quad_scoreboard;
		glyph_t  glyph_mem [GLYPH_ENTRIES];
		longint  origin_x, origin_y, line_width, inv_w, inv_h, line_step;
		longint  cursor_x, cursor_y, line_run;
		bit      wrap_pending;
		int      char_count;
		corner_t corners_due [$];
		int      errors;

		function new();
			foreach (glyph_mem[i])
				glyph_mem[i] = '0;
			origin_x   = longint'(ORIGIN_X_RST);
			origin_y   = longint'(ORIGIN_Y_RST);
			line_width = longint'(LINE_WIDTH_RST);
			inv_w      = longint'(INV_TEX_W_RST);
			inv_h      = longint'(INV_TEX_H_RST);
			line_step  = longint'(LINE_STEP_RST);
			errors     = 0;
			home();
		endfunction

		function void home();
			cursor_x     = origin_x;
			cursor_y     = origin_y;
			line_run     = 0;
			wrap_pending = 1'b0;
			char_count   = 0;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) << (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function int pending();
			return corners_due.size();
		endfunction

		function void write_reg(logic [2:0] idx, logic [20:0] data);
			case (idx)
				CFG_ORIGIN_X:   origin_x   = longint'($signed(data));
				CFG_ORIGIN_Y:   origin_y   = longint'($signed(data));
				CFG_LINE_WIDTH: line_width = longint'(data[19:0]);
				CFG_INV_TEX_W:  inv_w      = longint'(data[16:0]);
				CFG_INV_TEX_H:  inv_h      = longint'(data[16:0]);
				CFG_LINE_STEP:  line_step  = longint'(data[19:0]);
				default: ;
			endcase
		endfunction

		// advance the text state by one accepted beat
		function void note_beat(beat_t b);
			glyph_t  g;
			longint  cw, ch, u1, u2, v1, v2, xo, yo, adv, top, bot, right;
			longint  px [4];
			longint  py [4];
			longint  pu [4];
			longint  pv [4];
			corner_t c;
			case (b.cmd)
				CMD_LOAD:    glyph_mem[b.code] = b.g;
				CMD_RESTART: home();
				CMD_LAYOUT: begin
					g  = glyph_mem[b.code];
					cw = longint'(g.gw) * inv_w;
					ch = longint'(g.gh) * inv_h;
					u1 = longint'(g.gx) * inv_w;
					u2 = u1 + cw;
					v1 = (longint'(1) << FRAC_BITS) - longint'(g.gy) * inv_h;
					v2 = v1 - ch;
					xo = longint'(g.xoff) * inv_w;
					yo = longint'(g.yoff) * inv_h;
					top   = cursor_y - yo;
					bot   = cursor_y - ch - yo;
					right = cursor_x + cw;
					// corners: top-left, bottom-left, bottom-right, top-right
					px = '{cursor_x, cursor_x, right, right};
					py = '{top, bot, bot, top};
					pu = '{u1, u1, u2, u2};
					pv = '{v1, v2, v2, v1};
					for (int k = 0; k < 4; k++) begin
						c.x    = 21'(clamp(px[k], 21));
						c.y    = 21'(clamp(py[k], 21));
						c.u    = 18'(clamp(pu[k], 18));
						c.v    = 18'(clamp(pv[k], 18));
						c.num  = 12'(char_count * 4 + k);
						c.last = (k == int'(LAST_CORNER));
						corners_due = {corners_due, c};
					end
					// advance the cursor, then wrap on a space once the line is full
					adv      = longint'(g.xadv) * inv_w + xo;
					line_run = clamp(line_run + adv, 21);
					if (line_run >= line_width)
						wrap_pending = 1'b1;
					cursor_x = clamp(cursor_x + adv, 21);
					if (wrap_pending && b.code == SPACE_CODE) begin
						cursor_x     = origin_x;
						cursor_y     = clamp(cursor_y - line_step, 21);
						wrap_pending = 1'b0;
						line_run     = 0;
					end
					char_count++;
					if (char_count >= MAX_CHARS)
						char_count = 0;
				end
				default: ;
			endcase
		endfunction

		function void match(string field, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void check_corner(corner_t got);
			corner_t want;
			if (corners_due.size() == 0) begin
				errors++;
				$display("%0t: corner with no expectation, expected none, got vertex %0d",
					$time, got.num);
				return;
			end
			want = corners_due.pop_front();
			match("vert_x", want.x, got.x);
			match("vert_y", want.y, got.y);
			match("tex_u", want.u, got.u);
			match("tex_v", want.v, got.v);
			match("vertex_number", want.num, got.num);
			match("last", want.last, got.last);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         cmd = CMD_LOAD;
	logic [7:0]         char_code = '0;
	logic [11:0]        glyph_x = '0;
	logic [11:0]        glyph_y = '0;
	logic [11:0]        glyph_width = '0;
	logic [11:0]        glyph_height = '0;
	logic signed [11:0] glyph_xoffset = '0;
	logic signed [11:0] glyph_yoffset = '0;
	logic [11:0]        glyph_xadvance = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [20:0] vert_x;
	logic signed [20:0] vert_y;
	logic signed [17:0] tex_u;
	logic signed [17:0] tex_v;
	logic [11:0]        vertex_number;
	logic               last;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [20:0]        cfg_data = '0;

	quad_scoreboard sb;
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int holdoff_left  = 0;

	glyph_quad_layout_wrap_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.char_code      (char_code),
		.glyph_x        (glyph_x),
		.glyph_y        (glyph_y),
		.glyph_width    (glyph_width),
		.glyph_height   (glyph_height),
		.glyph_xoffset  (glyph_xoffset),
		.glyph_yoffset  (glyph_yoffset),
		.glyph_xadvance (glyph_xadvance),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.vert_x         (vert_x),
		.vert_y         (vert_y),
		.tex_u          (tex_u),
		.tex_v          (tex_v),
		.vertex_number  (vertex_number),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// receiver: long hold-off first, otherwise random stall
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			out_stall <= 1'b1;
			holdoff_left = holdoff_left - 1;
		end else begin
			out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	// check every corner beat taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_corner('{vert_x, vert_y, tex_u, tex_v, vertex_number, last});
	end

	// end the run if it hangs
	initial begin
		#2_000_000;
		$display("glyph_quad_layout_wrap_unit_tb: errors");
		$finish;
	end

	function automatic beat_t load_beat(logic [7:0] code, logic [11:0] gx, logic [11:0] gy,
		logic [11:0] gw, logic [11:0] gh, logic signed [11:0] xoff,
		logic signed [11:0] yoff, logic [11:0] xadv);
		beat_t b;
		b.cmd  = CMD_LOAD;
		b.code = code;
		b.g    = '{gx, gy, gw, gh, xoff, yoff, xadv};
		return b;
	endfunction

	function automatic beat_t cmd_beat(logic [1:0] op, logic [7:0] code);
		beat_t b;
		b      = '0;
		b.cmd  = op;
		b.code = code;
		return b;
	endfunction

	// codes that get reused so layouts mostly hit loaded glyphs
	function automatic logic [7:0] common_code();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return SPACE_CODE;
			2: return CODE_UPPER_A;
			3: return CODE_LOWER_A;
			4: return 8'd128;
			default: return CODE_TOP;
		endcase
	endfunction

	function automatic beat_t random_beat();
		beat_t b;
		int    sel;
		b.code      = $urandom_range(1) ? common_code() : 8'($urandom);
		b.g.gx      = 12'($urandom);
		b.g.gy      = 12'($urandom);
		b.g.gw      = 12'($urandom);
		b.g.gh      = 12'($urandom);
		b.g.xoff    = 12'($urandom);
		b.g.yoff    = 12'($urandom);
		b.g.xadv    = 12'($urandom);
		sel = $urandom_range(99);
		if (sel < 16) begin
			b.cmd = CMD_LOAD;
			// mostly glyph-sized metrics so the cursor walks rather than saturates
			if ($urandom_range(99) < 60) begin
				b.g.gw   = 12'($urandom_range(63));
				b.g.gh   = 12'($urandom_range(63));
				b.g.xoff = 12'(int'($urandom_range(16)) - 8);
				b.g.yoff = 12'(int'($urandom_range(16)) - 8);
				b.g.xadv = 12'($urandom_range(255));
			end
		end else if (sel < 21) begin
			b.cmd = CMD_RESTART;
		end else if (sel < 23) begin
			b.cmd = CMD_SPARE;
		end else begin
			b.cmd = CMD_LAYOUT;
			if ($urandom_range(99) < 30)
				b.code = SPACE_CODE;
		end
		return b;
	endfunction

	// present one beat, hold it while stalled
	task automatic offer(beat_t b);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(5)) @(negedge clk);
		end
		@(negedge clk);
		cmd            <= b.cmd;
		char_code      <= b.code;
		glyph_x        <= b.g.gx;
		glyph_y        <= b.g.gy;
		glyph_width    <= b.g.gw;
		glyph_height   <= b.g.gh;
		glyph_xoffset  <= b.g.xoff;
		glyph_yoffset  <= b.g.yoff;
		glyph_xadvance <= b.g.xadv;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b);
	endtask

	// drop valid and wait for every corner plus the pipeline depth
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [20:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
	endtask

	task automatic set_regs(logic [20:0] ox, logic [20:0] oy, logic [20:0] lw,
		logic [20:0] iw, logic [20:0] ih, logic [20:0] ls);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_LINE_WIDTH, lw);
		write_reg(CFG_INV_TEX_W, iw);
		write_reg(CFG_INV_TEX_H, ih);
		write_reg(CFG_LINE_STEP, ls);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// a character under the old cursor, then a restart to pick up the new origin
	task automatic start_text();
		offer(cmd_beat(CMD_LAYOUT, CODE_LOWER_A));
		offer(cmd_beat(CMD_RESTART, 8'd0));
	endtask

	task automatic run_random(int count, int idle_p, int stall_p, bit pause_mid);
		send_idle_pct = idle_p;
		stall_pct     = stall_p;
		for (int i = 0; i < count; i++) begin
			if (pause_mid && i == count / 2) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.pending() != 0) @(posedge clk);
			end
			offer(random_beat());
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: unloaded glyph, metric extremes, wrap on a space
		offer(cmd_beat(CMD_LAYOUT, CODE_UPPER_A));
		offer(load_beat(8'd0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, -12'sd2048, 12'sd2047,
			12'hFFF));
		offer(cmd_beat(CMD_LAYOUT, 8'd0));
		offer(load_beat(CODE_TOP, 12'd0, 12'd0, 12'd0, 12'd0, 12'sd2047, -12'sd2048, 12'd0));
		offer(cmd_beat(CMD_LAYOUT, CODE_TOP));
		offer(load_beat(SPACE_CODE, 12'd10, 12'd20, 12'd8, 12'd12, 12'sd1, -12'sd3, 12'd9));
		offer(load_beat(CODE_LOWER_A, 12'd100, 12'd200, 12'd30, 12'd40, -12'sd2, 12'sd5,
			12'd200));
		offer(cmd_beat(CMD_RESTART, 8'd0));
		offer(cmd_beat(CMD_LAYOUT, CODE_LOWER_A));
		offer(cmd_beat(CMD_LAYOUT, SPACE_CODE));
		offer(cmd_beat(CMD_LAYOUT, CODE_LOWER_A));
		offer(cmd_beat(CMD_LAYOUT, CODE_LOWER_A));
		offer(cmd_beat(CMD_LAYOUT, SPACE_CODE));
		offer(cmd_beat(CMD_LAYOUT, SPACE_CODE));
		offer(cmd_beat(CMD_SPARE, CODE_LOWER_A));
		offer(cmd_beat(CMD_LAYOUT, CODE_LOWER_A));
		offer(cmd_beat(CMD_RESTART, 8'd0));
		offer(cmd_beat(CMD_LAYOUT, CODE_LOWER_A));

		// a burst of characters with spaces mixed in, no restart
		for (int i = 0; i < 24; i++)
			offer(cmd_beat(CMD_LAYOUT, $urandom_range(3) == 0 ? SPACE_CODE : common_code()));
		run_random(100, 0, 0, 1'b1);
		wait_drained();

		// upper origin corner, zero line width, unit reciprocals, largest line step
		write_reg(CFG_SPARE_A, 21'($urandom));
		write_reg(CFG_SPARE_B, 21'($urandom));
		set_regs(21'h0FFFFF, 21'h100000, 21'd0, 21'd65536, 21'd65536, 21'h0FFFFF);
		start_text();
		run_random(100, 50, 0, 1'b0);
		wait_drained();

		// opposite origin corner, widest line, masked reciprocal, no line step
		set_regs(21'h100000, 21'h0FFFFF, 21'h0FFFFF, 21'h1FFFFF, 21'd0, 21'd0);
		start_text();
		run_random(100, 0, 50, 1'b0);
		wait_drained();

		// any register value
		set_regs(21'($urandom), 21'($urandom), 21'($urandom), 21'($urandom),
			21'($urandom), 21'($urandom));
		start_text();
		run_random(100, 18, 18, 1'b0);
		wait_drained();

		// ordinary text settings; the receiver holds off while beats keep coming
		set_regs(21'($urandom_range(65535)), 21'($urandom_range(65535)), 21'd32768,
			21'd256, 21'd128, 21'd6554);
		start_text();
		holdoff_left = 300;
		run_random(100, 0, 0, 1'b0);
		wait_drained();

		if (sb.errors == 0)
			$display("glyph_quad_layout_wrap_unit_tb: clean");
		else
			$display("glyph_quad_layout_wrap_unit_tb: errors");
		$finish;
	end

endmodule

### sim.f
src/gqlw_pkg.sv
src/gqlw_glyph_ram.sv
src/gqlw_metric.sv
src/gqlw_emit.sv
src/glyph_quad_layout_wrap_unit.sv
verif/glyph_quad_layout_wrap_unit_tb.sv
